[hw/rtl/assert_macros.svh]
// Assertion macros for the scheduler RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg)
`define ASSERT_IMPLY(label, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/dles_pkg.sv]
// Fixed field widths and stream word layouts for the delta-list event scheduler.
// No dependencies.
package dles_pkg;
    localparam int ID_W     = 4;
    localparam int AMT_W    = 31;
    localparam int S_DATA_W = 40;  // event_id + amount, padded to bytes
    localparam int M_DATA_W = 8;   // fired_event, padded to a byte

    // func codes carried on s_axis_tuser
    typedef enum logic {FUNC_SCHEDULE = 1'b0, FUNC_ELAPSE = 1'b1} t_func;
endpackage

[hw/rtl/delta_list_event_scheduler.sv]
// Delta-list event scheduler: pending events in a linked list kept in two
// memories with registered read ports (delta counts and successor links).
// Depends on dles_pkg and assert_macros.svh.
//
//  channel | dir | tdata (low bit up)                | tuser | tlast
//  s_axis  | in  | event_id[3:0], amount[34:4], pad  | func  | -
//  m_axis  | out | fired_event[3:0], pad            | -     | last_fired
//
// A schedule first walks the list to unlink the entry when it is already
// pending, then walks it from the head to insert it; every step of both
// walks waits on the single read port of each memory.
// An elapse updates the head delta, or, when it fires, pops fired words in turn.
// Reset (i_rst_n low, synchronous) empties the list at once; no clearing pass.
// A waiting output word never blocks input; only a further fired word stalls.
`include "assert_macros.svh"

module delta_list_event_scheduler #(
    parameter int NUM_EVENTS  = 16,
    parameter int COUNT_WIDTH = 31
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dles_pkg::S_DATA_W-1:0] s_axis_tdata,  // event_id, amount, zero pad
    input  logic                         s_axis_tuser,  // func
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dles_pkg::M_DATA_W-1:0] m_axis_tdata,  // fired_event, zero pad
    output logic                         m_axis_tlast   // last_fired
);
    localparam int SW   = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int CNTW = $clog2(NUM_EVENTS + 1);
    localparam int CW   = COUNT_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_U_CHK, S_U_WAIT, S_U_RD, S_U_FIN,
        S_I_INIT, S_I_CHK, S_I_CMP, S_I_FIN, S_I_FIN2,
        S_E_CMP, S_P_RD, S_P_RD2, S_P_EMIT
    } t_state;

    // list storage
    logic [CW-1:0] delta_mem [NUM_EVENTS];
    logic [SW-1:0] next_mem  [NUM_EVENTS];
    logic [CW-1:0] r_rd_delta;
    logic [SW-1:0] r_rd_next;

    t_state              r_state, n_state;
    logic [NUM_EVENTS-1:0] r_pending, n_pending;
    logic [CNTW-1:0]     r_count, n_count;
    logic [SW-1:0]       r_head, n_head;
    logic [SW-1:0]       r_id, n_id;
    logic [SW-1:0]       r_cur, n_cur;
    logic [SW-1:0]       r_prev, n_prev;
    logic                r_have_prev, n_have_prev;
    logic [SW-1:0]       r_succ, n_succ;
    logic [CNTW-1:0]     r_pos, n_pos;
    logic [CW-1:0]       r_rem, n_rem;
    logic [CW-1:0]       r_d, n_d;
    logic [3:0]          r_k, n_k;
    logic                r_out_valid, n_out_valid;
    logic [dles_pkg::ID_W-1:0] r_out_id, n_out_id;
    logic                r_out_last, n_out_last;

    logic [SW-1:0] w_raddr;
    logic          w_d_we, w_n_we;
    logic [SW-1:0] w_d_waddr, w_n_waddr;
    logic [CW-1:0] w_d_wdata;
    logic [SW-1:0] w_n_wdata;

    logic [dles_pkg::ID_W-1:0]  w_in_id;
    logic [dles_pkg::AMT_W-1:0] w_in_amt;
    logic [CW:0]                w_sum;
    logic [CNTW:0]              w_pos_inc;
    logic                       w_last;

    assign w_in_id   = s_axis_tdata[dles_pkg::ID_W-1:0];
    assign w_in_amt  = s_axis_tdata[dles_pkg::ID_W +: dles_pkg::AMT_W];
    assign w_sum     = {1'b0, r_rd_delta} + {1'b0, r_d};
    assign w_pos_inc = {1'b0, r_pos} + (CNTW+1)'(1);
    // the popped word is last when the list runs out, the next delta is
    // nonzero, or the per-elapse word limit is reached
    assign w_last    = (r_count == CNTW'(1)) || (r_rd_delta != '0) || (r_k == 4'hf);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = dles_pkg::M_DATA_W'(r_out_id);
    assign m_axis_tlast  = r_out_last;

    always_comb begin
        n_state = r_state;   n_pending = r_pending; n_count = r_count;
        n_head = r_head;     n_id = r_id;           n_cur = r_cur;
        n_prev = r_prev;     n_have_prev = r_have_prev;
        n_succ = r_succ;     n_pos = r_pos;         n_rem = r_rem;
        n_d = r_d;           n_k = r_k;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_id = r_out_id; n_out_last = r_out_last;
        w_raddr = r_cur;
        w_d_we = 1'b0; w_d_waddr = r_cur; w_d_wdata = r_d;
        w_n_we = 1'b0; w_n_waddr = r_id;  w_n_wdata = r_cur;
        unique case (r_state)
            S_IDLE: begin
                n_id  = SW'(w_in_id);
                n_rem = CW'(w_in_amt);
                n_cur = r_head;
                n_pos = '0;
                n_have_prev = 1'b0;
                w_raddr = r_head;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == dles_pkg::FUNC_ELAPSE) begin
                        if (r_count != '0) n_state = S_E_CMP;
                    end else if (32'(w_in_id) < NUM_EVENTS) begin
                        n_state = r_pending[SW'(w_in_id)] ? S_U_CHK : S_I_INIT;
                    end
                end
            end
            // walk to the pending entry, tracking its predecessor
            S_U_CHK: begin
                if (r_cur == r_id) begin
                    w_raddr = r_id;
                    n_state = S_U_RD;
                end else begin
                    w_raddr = r_cur;
                    n_prev = r_cur;
                    n_have_prev = 1'b1;
                    n_pos = CNTW'(w_pos_inc);
                    n_state = S_U_WAIT;
                end
            end
            S_U_WAIT: begin
                n_cur = r_rd_next;
                n_state = S_U_CHK;
            end
            S_U_RD: begin
                n_succ = r_rd_next;
                n_d = r_rd_delta;
                w_raddr = r_rd_next;
                if (w_pos_inc < {1'b0, r_count}) begin
                    n_state = S_U_FIN;
                end else begin
                    n_pending[r_id] = 1'b0;
                    n_count = r_count - CNTW'(1);
                    n_state = S_I_INIT;
                end
            end
            // fold the removed delta into the successor, relink
            S_U_FIN: begin
                w_d_we = 1'b1;
                w_d_waddr = r_succ;
                w_d_wdata = w_sum[CW] ? {CW{1'b1}} : w_sum[CW-1:0];
                if (r_have_prev) begin
                    w_n_we = 1'b1;
                    w_n_waddr = r_prev;
                    w_n_wdata = r_succ;
                end else begin
                    n_head = r_succ;
                end
                n_pending[r_id] = 1'b0;
                n_count = r_count - CNTW'(1);
                n_state = S_I_INIT;
            end
            S_I_INIT: begin
                n_cur = r_head;
                n_pos = '0;
                n_have_prev = 1'b0;
                n_state = S_I_CHK;
            end
            S_I_CHK: begin
                w_raddr = r_cur;
                n_state = (r_pos < r_count && r_rem != '0) ? S_I_CMP : S_I_FIN;
            end
            S_I_CMP: begin
                if (r_rd_delta <= r_rem) begin
                    n_rem = r_rem - r_rd_delta;
                    n_prev = r_cur;
                    n_have_prev = 1'b1;
                    n_pos = CNTW'(w_pos_inc);
                    n_cur = r_rd_next;
                    n_state = S_I_CHK;
                end else begin
                    n_d = r_rd_delta;
                    n_state = S_I_FIN;
                end
            end
            S_I_FIN: begin
                w_n_we = 1'b1;
                w_n_waddr = r_id;
                if (r_pos < r_count) begin
                    w_n_wdata = r_cur;
                    if (r_rem != '0) begin
                        w_d_we = 1'b1;
                        w_d_waddr = r_cur;
                        w_d_wdata = r_d - r_rem;
                    end
                end else begin
                    w_n_wdata = '0;
                end
                n_state = S_I_FIN2;
            end
            S_I_FIN2: begin
                if (r_have_prev) begin
                    w_n_we = 1'b1;
                    w_n_waddr = r_prev;
                    w_n_wdata = r_id;
                end else begin
                    n_head = r_id;
                end
                w_d_we = 1'b1;
                w_d_waddr = r_id;
                w_d_wdata = r_rem;
                n_pending[r_id] = 1'b1;
                n_count = r_count + CNTW'(1);
                n_state = S_IDLE;
            end
            // count down the head; fire when it would go below zero
            S_E_CMP: begin
                if (r_rem <= r_rd_delta) begin
                    w_d_we = 1'b1;
                    w_d_waddr = r_head;
                    w_d_wdata = r_rd_delta - r_rem;
                    n_state = S_IDLE;
                end else begin
                    n_k = '0;
                    n_state = S_P_RD;
                end
            end
            S_P_RD: begin
                w_raddr = r_head;
                n_state = S_P_RD2;
            end
            S_P_RD2: begin
                n_succ = r_rd_next;
                w_raddr = r_rd_next;
                n_state = S_P_EMIT;
            end
            S_P_EMIT: begin
                w_raddr = r_succ;  // hold the successor delta while stalled
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_id = dles_pkg::ID_W'(r_head);
                    n_out_last = w_last;
                    n_pending[r_head] = 1'b0;
                    n_count = r_count - CNTW'(1);
                    n_head = r_succ;
                    n_k = r_k + 4'd1;
                    n_state = w_last ? S_IDLE : S_P_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pending <= '0;
            r_count <= '0;
            r_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pending <= n_pending;
            r_count <= n_count;
            r_head <= n_head;
            r_out_valid <= n_out_valid;
        end
        r_id <= n_id;       r_cur <= n_cur;     r_prev <= n_prev;
        r_have_prev <= n_have_prev;             r_succ <= n_succ;
        r_pos <= n_pos;     r_rem <= n_rem;     r_d <= n_d;
        r_k <= n_k;         r_out_id <= n_out_id; r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_d_we) delta_mem[w_d_waddr] <= w_d_wdata;
        if (w_n_we) next_mem[w_n_waddr] <= w_n_wdata;
        r_rd_delta <= delta_mem[w_raddr];
        r_rd_next  <= next_mem[w_raddr];
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNTW'(NUM_EVENTS), "list count overflow")
    `ASSERT_ALWAYS(a_count_match, i_clk, i_rst_n, 32'(r_count) == $countones(r_pending), "count and pending bits disagree")
    `ASSERT_IMPLY(a_empty_last, i_clk, i_rst_n, r_out_valid && r_count == '0, r_out_last, "list drained without last mark")
endmodule
